@@ rtl/rtwb_pkg.sv @@
// Package for the raw two-wire bus master: command codes, micro-ops,
// controller/datapath command and status structs, start/stop sequence table.
// No dependencies.
package rtwb_pkg;

	localparam int          TICK_W    = 5;
	localparam int          BYTE_W    = 8;
	localparam logic [4:0]  MAX_TICKS = 5'd31;
	localparam logic [4:0]  BYTE_BITS = 5'd8;

	// last step index of the fixed start and stop sequences
	localparam logic [2:0]  START_LAST = 3'd5;
	localparam logic [2:0]  STOP_LAST  = 3'd6;

	// configuration register indexes
	localparam logic        CFG_LSB_FIRST = 1'b0;
	localparam logic        CFG_PUSH_PULL = 1'b1;

	typedef enum logic [3:0] {
		ACT_START  = 4'd0,
		ACT_STOP   = 4'd1,
		ACT_WRBYTE = 4'd2,
		ACT_RDBYTE = 4'd3,
		ACT_WRBIT  = 4'd4,
		ACT_RDBIT  = 4'd5,
		ACT_TICKS  = 4'd6,
		ACT_CLKHI  = 4'd7,
		ACT_CLKLO  = 4'd8,
		ACT_DATHI  = 4'd9,
		ACT_DATLO  = 4'd10,
		ACT_PEEK   = 4'd11,
		ACT_SETUP  = 4'd12
	} action_t;

	typedef enum logic [1:0] {
		HOLD_SETTLE = 2'd0,
		HOLD_CLOCK  = 2'd1,
		HOLD_NONE   = 2'd2
	} hold_t;

	// one micro-op = one pin-state change plus one emitted segment
	typedef enum logic [3:0] {
		OP_CLK_LATCH,      // clock level forced low, enable kept
		OP_DAT_HIGH,
		OP_DAT_LOW,
		OP_CLK_HIGH,
		OP_CLK_LOW,        // also counts down one pulse
		OP_DELAY,          // repeat current state, settle hold
		OP_CLK_LOW_SETTLE, // first step of bus turnaround
		OP_DAT_DRIVE,      // drive data at latched level
		OP_DAT_RELEASE,
		OP_DAT_BIT,        // next outgoing bit, shift
		OP_CLK_HIGH_SAMPLE,// clock high, shift in sample
		OP_PEEK,
		OP_SETUP
	} op_t;

	// how the datapath initializes on a command transfer
	typedef enum logic [2:0] {
		LD_NONE,
		LD_WBYTE,
		LD_WBIT,
		LD_RBYTE,
		LD_RBIT,
		LD_TICKS
	} ld_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_SHIFT,
		RD_SAMPLE
	} rd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEQ,
		ST_PRE1,
		ST_PRE2,
		ST_BIT,
		ST_HI,
		ST_LO,
		ST_ONE
	} state_t;

	typedef struct packed {
		logic load;
		ld_t  ld;
		logic emit;
		op_t  op;
		logic last;
		rd_t  rd;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_last;
	} sts_t;

	// fixed start and stop sequences
	function automatic op_t seq_op(input logic is_stop, input logic [2:0] step);
		op_t op;
		op = OP_DELAY;
		if (is_stop) begin
			unique case (step)
				3'd0: op = OP_CLK_LOW_SETTLE;
				3'd1: op = OP_DAT_DRIVE;
				3'd2: op = OP_DAT_LOW;
				3'd3: op = OP_CLK_HIGH;
				3'd4: op = OP_DAT_HIGH;
				3'd5: op = OP_DELAY;
				default: op = OP_CLK_LOW;
			endcase
		end else begin
			unique case (step)
				3'd0: op = OP_CLK_LATCH;
				3'd1: op = OP_DAT_HIGH;
				3'd2: op = OP_CLK_HIGH;
				3'd3: op = OP_DELAY;
				3'd4: op = OP_DAT_LOW;
				default: op = OP_CLK_LOW;
			endcase
		end
		return op;
	endfunction

endpackage

@@ rtl/rtwb_ctrl.sv @@
// Controller of the raw two-wire bus master: walks each command through its
// segment sequence and issues micro-ops to the datapath. Uses rtwb_pkg.
module rtwb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [3:0]        action,
	input  logic [4:0]        tick_count,
	input  rtwb_pkg::sts_t    sts,
	output logic              in_ready,
	output rtwb_pkg::cmd_t    cmd
);
	import rtwb_pkg::*;

	state_t     state_q, state_n;
	action_t    action_q, action_n;
	logic [2:0] step_q, step_n;
	logic       is_write, is_read, seq_last;

	assign is_write = (action_q == ACT_WRBYTE) || (action_q == ACT_WRBIT);
	assign is_read  = (action_q == ACT_RDBYTE) || (action_q == ACT_RDBIT);
	assign seq_last = (action_q == ACT_STOP) ? (step_q == STOP_LAST)
	                                         : (step_q == START_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			action_q <= ACT_SETUP;
			step_q   <= '0;
		end else begin
			state_q  <= state_n;
			action_q <= action_n;
			step_q   <= step_n;
		end
	end

	// next state and micro-op
	always_comb begin
		state_n  = state_q;
		action_n = action_q;
		step_n   = step_q;
		in_ready = 1'b0;
		cmd      = '{load: 1'b0, ld: LD_NONE, emit: 1'b0, op: OP_DELAY,
		             last: 1'b0, rd: RD_NONE};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					action_n = action_t'(action);
					step_n   = '0;
					unique case (action_t'(action))
						ACT_START, ACT_STOP: state_n = ST_SEQ;
						ACT_WRBYTE: begin cmd.ld = LD_WBYTE; state_n = ST_PRE1; end
						ACT_WRBIT:  begin cmd.ld = LD_WBIT;  state_n = ST_PRE1; end
						ACT_RDBYTE: begin cmd.ld = LD_RBYTE; state_n = ST_PRE1; end
						ACT_RDBIT:  begin cmd.ld = LD_RBIT;  state_n = ST_PRE1; end
						ACT_TICKS: begin
							cmd.ld = LD_TICKS;
							// zero pulses: nothing to emit
							if (tick_count != '0)
								state_n = ST_HI;
						end
						ACT_CLKHI, ACT_CLKLO, ACT_DATHI, ACT_DATLO, ACT_PEEK,
						ACT_SETUP: state_n = ST_ONE;
						default: state_n = ST_IDLE;
					endcase
				end
			end
			ST_SEQ: begin
				cmd.op   = seq_op(action_q == ACT_STOP, step_q);
				cmd.last = seq_last;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					step_n   = step_q + 3'd1;
					if (seq_last)
						state_n = ST_IDLE;
				end
			end
			ST_PRE1: begin
				cmd.op = OP_CLK_LOW_SETTLE;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_PRE2;
				end
			end
			ST_PRE2: begin
				cmd.op = is_write ? OP_DAT_DRIVE : OP_DAT_RELEASE;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = is_write ? ST_BIT : ST_HI;
				end
			end
			ST_BIT: begin
				cmd.op = OP_DAT_BIT;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_HI;
				end
			end
			ST_HI: begin
				cmd.op = is_read ? OP_CLK_HIGH_SAMPLE : OP_CLK_HIGH;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_LO;
				end
			end
			ST_LO: begin
				cmd.op   = OP_CLK_LOW;
				cmd.last = sts.cnt_last;
				if (sts.cnt_last) begin
					if (action_q == ACT_RDBYTE)
						cmd.rd = RD_SHIFT;
					else if (action_q == ACT_RDBIT)
						cmd.rd = RD_SAMPLE;
				end
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.cnt_last)
						state_n = ST_IDLE;
					else
						state_n = is_write ? ST_BIT : ST_HI;
				end
			end
			ST_ONE: begin
				cmd.last = 1'b1;
				unique case (action_q)
					ACT_CLKHI: cmd.op = OP_CLK_HIGH;
					ACT_CLKLO: cmd.op = OP_CLK_LOW;
					ACT_DATHI: cmd.op = OP_DAT_HIGH;
					ACT_DATLO: cmd.op = OP_DAT_LOW;
					ACT_PEEK: begin
						cmd.op = OP_PEEK;
						cmd.rd = RD_SAMPLE;
					end
					ACT_SETUP: cmd.op = OP_SETUP;
					default:   cmd.op = OP_DELAY;
				endcase
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/rtwb_dpath.sv @@
// Datapath of the raw two-wire bus master: pin state, shift register, pulse
// counter, configuration registers and the segment output register.
// Uses rtwb_pkg; driven by rtwb_ctrl.
module rtwb_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic              cfg_data,
	input  logic [7:0]        write_value,
	input  logic [4:0]        tick_count,
	input  logic [7:0]        line_samples,
	input  rtwb_pkg::cmd_t    cmd,
	output rtwb_pkg::sts_t    sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              clk_drive,
	output logic              clk_level,
	output logic              dat_drive,
	output logic              dat_level,
	output logic [1:0]        hold_class,
	output logic [7:0]        read_value,
	output logic              read_valid,
	output logic              last_segment
);
	import rtwb_pkg::*;

	logic                lsb_first_q, push_pull_q;
	logic [1:0]          clk_pin_q, dat_pin_q, clk_pin_n, dat_pin_n;
	logic [BYTE_W-1:0]   sr_q, sr_n, samp_q, samp_n;
	logic                samp0_q;
	logic [TICK_W-1:0]   cnt_q, cnt_n, ticks_sat;
	logic [1:0]          high_st;
	logic                bit_out, out_free;
	hold_t               hold;
	logic [BYTE_W-1:0]   rd_val;

	// output register slot
	logic                valid_q;
	logic [1:0]          seg_clk_q, seg_dat_q;
	hold_t               seg_hold_q;
	logic [BYTE_W-1:0]   seg_rd_q;
	logic                seg_rdv_q, seg_last_q;

	assign high_st   = push_pull_q ? 2'b11 : 2'b00;
	assign bit_out   = lsb_first_q ? sr_q[0] : sr_q[BYTE_W-1];
	assign ticks_sat = (tick_count > MAX_TICKS) ? MAX_TICKS : tick_count;
	assign out_free  = !valid_q || out_ready;
	assign sts       = '{out_free: out_free, cnt_last: (cnt_q == TICK_W'(1))};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_first_q <= 1'b0;
			push_pull_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_LSB_FIRST: lsb_first_q <= cfg_data;
				CFG_PUSH_PULL: push_pull_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pin state update for the current micro-op
	always_comb begin
		clk_pin_n = clk_pin_q;
		dat_pin_n = dat_pin_q;
		sr_n      = sr_q;
		samp_n    = samp_q;
		cnt_n     = cnt_q;
		hold      = HOLD_SETTLE;
		unique case (cmd.op)
			OP_CLK_LATCH:      clk_pin_n = clk_pin_q & 2'b10;
			OP_DAT_HIGH:       dat_pin_n = high_st;
			OP_DAT_LOW:        dat_pin_n = 2'b10;
			OP_CLK_HIGH: begin
				clk_pin_n = high_st;
				hold      = HOLD_CLOCK;
			end
			OP_CLK_LOW: begin
				clk_pin_n = 2'b10;
				hold      = HOLD_CLOCK;
				cnt_n     = cnt_q - TICK_W'(1);
			end
			OP_DELAY:          ;
			OP_CLK_LOW_SETTLE: clk_pin_n = 2'b10;
			OP_DAT_DRIVE: begin
				dat_pin_n = dat_pin_q | 2'b10;
				hold      = HOLD_NONE;
			end
			OP_DAT_RELEASE:    dat_pin_n = 2'b00;
			OP_DAT_BIT: begin
				dat_pin_n = bit_out ? high_st : 2'b10;
				sr_n      = lsb_first_q ? {1'b0, sr_q[BYTE_W-1:1]}
				                        : {sr_q[BYTE_W-2:0], 1'b0};
			end
			OP_CLK_HIGH_SAMPLE: begin
				clk_pin_n = high_st;
				hold      = HOLD_CLOCK;
				sr_n      = lsb_first_q ? {samp_q[0], sr_q[BYTE_W-1:1]}
				                        : {sr_q[BYTE_W-2:0], samp_q[0]};
				samp_n    = {1'b0, samp_q[BYTE_W-1:1]};
			end
			OP_PEEK: begin
				dat_pin_n = dat_pin_q & 2'b01;
				hold      = HOLD_NONE;
			end
			OP_SETUP: begin
				clk_pin_n = 2'b10;
				dat_pin_n = 2'b00;
				hold      = HOLD_NONE;
			end
			default: ;
		endcase
	end

	// read result carried on the last segment
	always_comb begin
		unique case (cmd.rd)
			RD_SHIFT:  rd_val = sr_n;
			RD_SAMPLE: rd_val = {{(BYTE_W-1){1'b0}}, samp0_q};
			default:   rd_val = '0;
		endcase
	end

	// pin state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_pin_q <= 2'b00;
			dat_pin_q <= 2'b00;
			sr_q      <= '0;
			cnt_q     <= '0;
		end else if (cmd.load) begin
			unique case (cmd.ld)
				LD_WBYTE: begin sr_q <= write_value;             cnt_q <= BYTE_BITS; end
				LD_WBIT:  begin sr_q <= {BYTE_W{write_value[0]}}; cnt_q <= TICK_W'(1); end
				LD_RBYTE: begin sr_q <= '0;                      cnt_q <= BYTE_BITS; end
				LD_RBIT:  begin sr_q <= '0;                      cnt_q <= TICK_W'(1); end
				LD_TICKS: cnt_q <= ticks_sat;
				default: ;
			endcase
		end else if (cmd.emit) begin
			clk_pin_q <= clk_pin_n;
			dat_pin_q <= dat_pin_n;
			sr_q      <= sr_n;
			cnt_q     <= cnt_n;
		end
	end

	// sampled data levels, latched per command
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			samp_q  <= line_samples;
			samp0_q <= line_samples[0];
		end else if (cmd.emit) begin
			samp_q <= samp_n;
		end
	end

	// segment output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			seg_clk_q  <= clk_pin_n;
			seg_dat_q  <= dat_pin_n;
			seg_hold_q <= hold;
			seg_rd_q   <= rd_val;
			seg_rdv_q  <= (cmd.rd != RD_NONE);
			seg_last_q <= cmd.last;
		end
	end

	assign out_valid    = valid_q;
	assign clk_drive    = seg_clk_q[1];
	assign clk_level    = seg_clk_q[0];
	assign dat_drive    = seg_dat_q[1];
	assign dat_level    = seg_dat_q[0];
	assign hold_class   = seg_hold_q;
	assign read_value   = seg_rd_q;
	assign read_valid   = seg_rdv_q;
	assign last_segment = seg_last_q;

endmodule

@@ rtl/raw_two_wire_bus_master.sv @@
// Top level of the raw two-wire bus master: command stream in, pin-segment
// stream out. Instantiates rtwb_ctrl and rtwb_dpath; uses rtwb_pkg.
//
// channel  | dir | handshake          | contents
// s_*      | in  | s_tvalid/s_tready  | one command (action in tuser)
// m_*      | out | m_tvalid/m_tready  | one pin segment, tlast on final one
// cfg_*    | in  | cfg_we             | lsb_first (0), push_pull (1)
//
// A command is taken in one transfer and then emits its segments (a 31-pulse
// tick run emits 62 segments); the controller issues one micro-op per cycle,
// while it is free, into the single segment output register.
// Reset leaves both pins released at level low and the block idle.
// A stalled m_tready holds the sequence; s_tready is high only when idle.
module raw_two_wire_bus_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // write_value[7:0], tick_count[12:8], line_samples[20:13]
	input  logic [3:0]  s_tuser,  // action[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // clk_drive[0], clk_level[1], dat_drive[2], dat_level[3],
	                              // hold_class[5:4], read_value[13:6], read_valid[14]
	output logic        m_tlast,  // last_segment
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic        cfg_data
);
	import rtwb_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic       clk_drive, clk_level, dat_drive, dat_level, read_valid;
	logic [1:0] hold_class;
	logic [7:0] read_value;

	rtwb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.action     (s_tuser),
		.tick_count (s_tdata[12:8]),
		.sts        (sts),
		.in_ready   (s_tready),
		.cmd        (cmd)
	);

	rtwb_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.write_value  (s_tdata[7:0]),
		.tick_count   (s_tdata[12:8]),
		.line_samples (s_tdata[20:13]),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.clk_drive    (clk_drive),
		.clk_level    (clk_level),
		.dat_drive    (dat_drive),
		.dat_level    (dat_level),
		.hold_class   (hold_class),
		.read_value   (read_value),
		.read_valid   (read_valid),
		.last_segment (m_tlast)
	);

	assign m_tdata = {1'b0, read_valid, read_value, hold_class,
	                  dat_level, dat_drive, clk_level, clk_drive};

endmodule

@@ rtl/rtwb_checker.sv @@
// Port-level checks for the raw two-wire bus master, bound to the top level.
// Depends only on the top-level ports.
module rtwb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a read result only rides on the final segment of a command
	a_read_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tlast)
		else $error("read result on a non-final segment");

	// without a read result the value field is zero
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[14] |-> m_tdata[13:6] == 8'd0)
		else $error("read value set without read_valid");

	// no new command while a command's segments are still going out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("command taken in the middle of a sequence");

	// stalled segment holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("segment changed while stalled");

endmodule

bind raw_two_wire_bus_master rtwb_checker u_rtwb_checker (.*);

@@ sim/tb_raw_two_wire_bus_master.sv @@
// Self-checking testbench for raw_two_wire_bus_master: drives command transfers, predicts
// every pin segment in a behavioral model and compares each segment transfer field by field.
// Depends on rtl/rtwb_pkg.sv and rtl/raw_two_wire_bus_master.sv.
`timescale 1ns / 100ps

module tb_raw_two_wire_bus_master;
	import rtwb_pkg::*;

	localparam int         QUIET_LIMIT     = 2000;
	localparam int         DRAIN_CYCLES    = 70;
	localparam int         NUM_PHASES      = 8;
	localparam logic [3:0] ACT_UNDEF_FIRST = 4'd13;
	localparam logic [3:0] ACT_UNDEF_LAST  = 4'd15;
	localparam logic [1:0] PIN_DRIVEN_LOW  = 2'b10;
	localparam logic [1:0] PIN_RELEASED    = 2'b00;

	// one expected pin segment
	typedef struct packed {
		logic       clk_drive;
		logic       clk_level;
		logic       dat_drive;
		logic       dat_level;
		hold_t      hold_class;
		logic [7:0] read_value;
		logic       read_valid;
		logic       last_segment;
	} seg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // write_value[7:0], tick_count[12:8], line_samples[20:13]
	logic [3:0]  s_tuser = '0;   // action[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // clk_drive, clk_level, dat_drive, dat_level, hold_class[5:4],
	                             // read_value[13:6], read_valid[14]
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic        cfg_data = 1'b0;

	// model state: pin bit 1 is drive enable, bit 0 the latched level
	logic [1:0]  pin_clk = PIN_RELEASED;
	logic [1:0]  pin_dat = PIN_RELEASED;
	logic        mode_lsb_first = 1'b0;
	logic        mode_push_pull = 1'b0;
	bit          idle_off = 1'b0;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	seg_t        cmd_segs[$];
	seg_t        expected_segments[$];

	raw_two_wire_bus_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- segment predictor ----------------

	function automatic void add_segment(hold_t h);
		seg_t s;
		s.clk_drive    = pin_clk[1];
		s.clk_level    = pin_clk[0];
		s.dat_drive    = pin_dat[1];
		s.dat_level    = pin_dat[0];
		s.hold_class   = h;
		s.read_value   = '0;
		s.read_valid   = 1'b0;
		s.last_segment = 1'b0;
		cmd_segs.push_back(s);
	endfunction

	// high is either released or actively driven, per push_pull
	function automatic logic [1:0] high_pin();
		return mode_push_pull ? 2'b11 : PIN_RELEASED;
	endfunction

	function automatic void drive_dat(logic high);
		pin_dat = high ? high_pin() : PIN_DRIVEN_LOW;
		add_segment(HOLD_SETTLE);
	endfunction

	function automatic void drive_clk(logic high);
		pin_clk = high ? high_pin() : PIN_DRIVEN_LOW;
		add_segment(HOLD_CLOCK);
	endfunction

	function automatic void clock_pulse();
		drive_clk(1'b1);
		drive_clk(1'b0);
	endfunction

	// bus turnaround toward output: clock low, then data driven at its latched level
	function automatic void turnaround_out();
		pin_clk = PIN_DRIVEN_LOW;
		add_segment(HOLD_SETTLE);
		pin_dat[1] = 1'b1;
		add_segment(HOLD_NONE);
	endfunction

	// bus turnaround toward input: clock low, then data released low
	function automatic void turnaround_in();
		pin_clk = PIN_DRIVEN_LOW;
		add_segment(HOLD_SETTLE);
		pin_dat = PIN_RELEASED;
		add_segment(HOLD_SETTLE);
	endfunction

	function automatic void predict_segments(logic [3:0] act, logic [7:0] wv, logic [4:0] tc,
	                                         logic [7:0] samples);
		logic       has_read;
		logic [7:0] rd;
		logic [4:0] n;
		seg_t       s;
		has_read = 1'b0;
		rd = '0;
		cmd_segs.delete();
		case (act)
			ACT_START: begin
				pin_clk[0] = 1'b0;
				add_segment(HOLD_SETTLE);
				drive_dat(1'b1);
				drive_clk(1'b1);
				add_segment(HOLD_SETTLE);
				drive_dat(1'b0);
				drive_clk(1'b0);
			end
			ACT_STOP: begin
				turnaround_out();
				drive_dat(1'b0);
				drive_clk(1'b1);
				drive_dat(1'b1);
				add_segment(HOLD_SETTLE);
				drive_clk(1'b0);
			end
			ACT_WRBYTE: begin
				turnaround_out();
				for (int i = 0; i < 8; i++) begin
					drive_dat(mode_lsb_first ? wv[i] : wv[7 - i]);
					clock_pulse();
				end
			end
			ACT_RDBYTE: begin
				turnaround_in();
				for (int i = 0; i < 8; i++) begin
					drive_clk(1'b1);
					rd = mode_lsb_first ? {samples[i], rd[7:1]} : {rd[6:0], samples[i]};
					drive_clk(1'b0);
				end
				has_read = 1'b1;
			end
			ACT_WRBIT: begin
				turnaround_out();
				drive_dat(wv[0]);
				clock_pulse();
			end
			ACT_RDBIT: begin
				turnaround_in();
				clock_pulse();
				rd = {7'd0, samples[0]};
				has_read = 1'b1;
			end
			ACT_TICKS: begin
				n = (tc > MAX_TICKS) ? MAX_TICKS : tc;
				for (int i = 0; i < n; i++)
					clock_pulse();
			end
			ACT_CLKHI: drive_clk(1'b1);
			ACT_CLKLO: drive_clk(1'b0);
			ACT_DATHI: drive_dat(1'b1);
			ACT_DATLO: drive_dat(1'b0);
			ACT_PEEK: begin
				pin_dat[1] = 1'b0;
				add_segment(HOLD_NONE);
				rd = {7'd0, samples[0]};
				has_read = 1'b1;
			end
			ACT_SETUP: begin
				pin_clk = PIN_DRIVEN_LOW;
				pin_dat = PIN_RELEASED;
				add_segment(HOLD_NONE);
			end
			default: ;  // undefined codes are ignored
		endcase
		// tag the final segment, carrying the read result if any
		if (cmd_segs.size() > 0) begin
			s = cmd_segs.pop_back();
			s.last_segment = 1'b1;
			if (has_read) begin
				s.read_value = rd;
				s.read_valid = 1'b1;
			end
			cmd_segs.push_back(s);
		end
		foreach (cmd_segs[i])
			expected_segments.push_back(cmd_segs[i]);
	endfunction

	// ---------------- command sender ----------------

	task automatic send_command(input logic [3:0] act, input logic [7:0] wv,
	                            input logic [4:0] tc, input logic [7:0] samples);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, samples, tc, wv};
		do @(posedge clk); while (!s_tready);
		predict_segments(act, wv, tc, samples);
	endtask

	// random payload; tick runs are mostly short to keep the run brief
	task automatic send_any(input logic [3:0] act);
		logic [4:0] tc;
		if (act == ACT_TICKS && $urandom_range(0, 15) != 0)
			tc = 5'($urandom_range(0, 3));
		else
			tc = 5'($urandom_range(0, 31));
		send_command(act, 8'($urandom_range(0, 255)), tc, 8'($urandom_range(0, 255)));
	endtask

	// stop sending until every predicted segment has come, then pause extra cycles
	task automatic wait_bus_idle(input int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_segments.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_mode(input logic lsb, input logic pp);
		cfg_we   <= 1'b1;
		cfg_addr <= CFG_LSB_FIRST;
		cfg_data <= lsb;
		@(posedge clk);
		cfg_addr <= CFG_PUSH_PULL;
		cfg_data <= pp;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_lsb_first = lsb;
		mode_push_pull = pp;
	endtask

	// optional setup, start, a few data commands, stop
	task automatic send_bus_transaction(output int n);
		int nops;
		n = 0;
		if ($urandom_range(0, 3) == 0) begin
			send_any(ACT_SETUP);
			n++;
		end
		send_any(ACT_START);
		n++;
		nops = $urandom_range(1, 4);
		repeat (nops) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: send_any(ACT_WRBYTE);
				4, 5, 6:    send_any(ACT_RDBYTE);
				7:          send_any(ACT_WRBIT);
				8:          send_any(ACT_RDBIT);
				9:          send_any(ACT_TICKS);
				10:         send_any(ACT_PEEK);
				default:    send_any(4'(ACT_CLKHI) + 4'($urandom_range(0, 3)));
			endcase
			n++;
		end
		send_any(ACT_STOP);
		n++;
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		send_command(ACT_SETUP, 8'h00, 5'd0, 8'h00);
		send_command(ACT_START, 8'h00, 5'd0, 8'h00);
		send_command(ACT_WRBYTE, 8'h00, 5'd0, 8'h00);
		send_command(ACT_WRBYTE, 8'hFF, 5'd31, 8'hFF);
		send_command(ACT_WRBYTE, 8'hA5, 5'd0, 8'h00);
		send_command(ACT_RDBYTE, 8'h00, 5'd0, 8'h00);
		send_command(ACT_RDBYTE, 8'hFF, 5'd0, 8'hFF);
		send_command(ACT_RDBYTE, 8'h00, 5'd0, 8'h5A);
		send_command(ACT_WRBIT, 8'hFE, 5'd0, 8'h00);
		send_command(ACT_WRBIT, 8'h01, 5'd0, 8'h00);
		send_command(ACT_RDBIT, 8'h00, 5'd0, 8'h01);
		send_command(ACT_RDBIT, 8'h00, 5'd0, 8'hFE);
		// zero-length tick run produces nothing
		send_command(ACT_TICKS, 8'h00, 5'd0, 8'h00);
		send_command(ACT_TICKS, 8'h00, 5'd1, 8'h00);
		send_command(ACT_TICKS, 8'h00, MAX_TICKS, 8'h00);
		send_command(ACT_CLKHI, 8'h00, 5'd0, 8'h00);
		send_command(ACT_DATHI, 8'h00, 5'd0, 8'h00);
		send_command(ACT_CLKLO, 8'h00, 5'd0, 8'h00);
		send_command(ACT_DATLO, 8'h00, 5'd0, 8'h00);
		send_command(ACT_PEEK, 8'h00, 5'd0, 8'h01);
		send_command(ACT_PEEK, 8'h00, 5'd0, 8'hFE);
		send_command(ACT_STOP, 8'h00, 5'd0, 8'h00);
		for (int a = ACT_UNDEF_FIRST; a <= ACT_UNDEF_LAST; a++)
			send_command(4'(a), 8'hFF, 5'd31, 8'hFF);
	endtask

	task automatic test_config_write(input int phase);
		wait_bus_idle(DRAIN_CYCLES);
		if (phase < 4)
			set_mode(phase[0], phase[1]);
		else
			set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_bus_transactions(input int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			send_bus_transaction(n);
			sent += n;
		end
	endtask

	// any code including undefined ones; ignored codes are not counted
	task automatic test_random_commands(input int n_items);
		int         sent;
		logic [3:0] act;
		sent = 0;
		while (sent < n_items) begin
			act = 4'($urandom_range(0, 15));
			send_any(act);
			if (act <= ACT_SETUP)
				sent++;
		end
	endtask

	// sender holds off until the segment stream has fully drained
	task automatic test_drain_pause();
		int n;
		send_bus_transaction(n);
		wait_bus_idle(0);
		send_bus_transaction(n);
	endtask

	// ---------------- segment receiver and checker ----------------

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin : segment_sink
		int   stall;
		seg_t want;
		@(posedge arst_n);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_segments.size() == 0) begin
				$error("segment transfer with none expected: tdata %h tlast %b", m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				want = expected_segments.pop_front();
				check_field("clk_drive", want.clk_drive, m_tdata[0]);
				check_field("clk_level", want.clk_level, m_tdata[1]);
				check_field("dat_drive", want.dat_drive, m_tdata[2]);
				check_field("dat_level", want.dat_level, m_tdata[3]);
				check_field("hold_class", want.hold_class, m_tdata[5:4]);
				check_field("read_value", want.read_value, m_tdata[13:6]);
				check_field("read_valid", want.read_valid, m_tdata[14]);
				check_field("last_segment", want.last_segment, m_tlast);
			end
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drain_pause();
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			test_config_write(phase);
			idle_off = (phase == 5);
			test_bus_transactions(32);
			test_random_commands(12);
		end
		idle_off = 1'b0;
		wait_bus_idle(DRAIN_CYCLES);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/rtwb_pkg.sv
rtl/rtwb_ctrl.sv
rtl/rtwb_dpath.sv
rtl/raw_two_wire_bus_master.sv
rtl/rtwb_checker.sv
sim/tb_raw_two_wire_bus_master.sv
